FILE: rtl/tmnl_pkg.sv
// ----------------------------------------------------------------------------
// tmnl_pkg: shared types, constants and walk functions
// Holds the register codes, field widths and the small position-walk helpers
// that step a coordinate through the cells of one axis of the torus.
// ----------------------------------------------------------------------------
`default_nettype none

package tmnl_pkg;

  // Grid and radius limits.
  localparam int MAX_SIDE   = 64;
  localparam int MAX_RADIUS = 5;
  localparam int MIN_SIDE   = 2;
  localparam int MIN_RADIUS = 1;

  // Field widths.
  localparam int IDX_W   = 12;                 // linear cell index
  localparam int SIDE_W  = 7;                  // grid_side register
  localparam int RAD_W   = 3;                  // radius register
  localparam int POS_W   = $clog2(MAX_SIDE);   // one coordinate
  localparam int WIDE_W  = SIDE_W + 1;         // signed-ish interval bounds
  localparam int LIN_W   = POS_W + SIDE_W;     // row * side + col
  localparam int DATA_W  = 16;                 // tdata, whole bytes

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIDE_W;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 1'd1;

  localparam logic [SIDE_W-1:0] GRID_SIDE_RST = SIDE_W'(MAX_SIDE);
  localparam logic [RAD_W-1:0]  RADIUS_RST    = RAD_W'(MIN_RADIUS);

  // Request to and response from the iterative divider.
  typedef struct packed {
    logic              start;
    logic [IDX_W-1:0]  dividend;
    logic [SIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quotient;
    logic [POS_W-1:0] remainder;
  } div_rsp_t;

  // Result of one step along an axis.
  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] pos;
  } walk_t;

  // Cyclic distance between two coordinates on a ring of the given size.
  function automatic logic [POS_W-1:0] cyc_dist(input logic [POS_W-1:0]  a,
                                                input logic [POS_W-1:0]  b,
                                                input logic [SIDE_W-1:0] side);
    logic [POS_W-1:0]  d;
    logic [SIDE_W-1:0] wrapd;
    d     = (a > b) ? (a - b) : (b - a);
    wrapd = side - SIDE_W'(d);
    if (SIDE_W'(d) > (side >> 1)) begin
      d = wrapd[POS_W-1:0];
    end
    return d;
  endfunction

  // Lowest coordinate within cyclic distance r of center.
  function automatic logic [POS_W-1:0] first_pos(input logic [POS_W-1:0]  center,
                                                 input logic [RAD_W-1:0]  r,
                                                 input logic [SIDE_W-1:0] side);
    logic [WIDE_W-1:0] lo;
    logic [WIDE_W-1:0] hi;
    logic              wrap;
    lo   = WIDE_W'(center) - WIDE_W'(r);
    hi   = WIDE_W'(center) + WIDE_W'(r);
    wrap = lo[WIDE_W-1] || (hi >= WIDE_W'(side));
    return wrap ? '0 : lo[POS_W-1:0];
  endfunction

  // Next coordinate above cur that lies within cyclic distance r of center.
  // The reachable set is one interval that may wrap, so at most one jump
  // over the gap is ever needed.
  function automatic walk_t next_pos(input logic [POS_W-1:0]  cur,
                                     input logic [POS_W-1:0]  center,
                                     input logic [RAD_W-1:0]  r,
                                     input logic [SIDE_W-1:0] side);
    logic [WIDE_W-1:0] lo;
    logic [WIDE_W-1:0] n;
    logic [WIDE_W-1:0] target;
    walk_t             res;
    lo       = WIDE_W'(center) - WIDE_W'(r);
    n        = WIDE_W'(cur) + WIDE_W'(1);
    target   = lo[WIDE_W-1] ? (lo + WIDE_W'(side)) : lo;
    res.done = 1'b0;
    res.pos  = n[POS_W-1:0];
    if (n == WIDE_W'(side)) begin
      res.done = 1'b1;
    end else if (cyc_dist(n[POS_W-1:0], center, side) <= POS_W'(r)) begin
      res.pos = n[POS_W-1:0];
    end else if (n <= target) begin
      res.pos = target[POS_W-1:0];
    end else begin
      res.done = 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tmnl_div.sv
// ----------------------------------------------------------------------------
// tmnl_div: iterative restoring divider
// Splits a linear index into quotient (row) and remainder (column), one
// quotient bit per cycle through a single shared subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module tmnl_div
  import tmnl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(IDX_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  dvd_r;   // dividend bits shift out, quotient bits in
  logic [SIDE_W-1:0] rem_r;
  logic [SIDE_W-1:0] dvs_r;

  logic [SIDE_W-1:0] rem_sh;
  logic              fits;

  assign rem_sh = {rem_r[SIDE_W-2:0], dvd_r[IDX_W-1]};
  assign fits   = (rem_sh >= dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      dvd_r  <= '0;
      rem_r  <= '0;
      dvs_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? (rem_sh - dvs_r) : rem_sh;
        dvd_r <= {dvd_r[IDX_W-2:0], fits};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(IDX_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r[POS_W-1:0];

`ifndef NO_ASSERTIONS
  // The remainder never reaches the divisor once an iteration has settled.
  a_rem_below_dvs : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  // Done is raised in the cycle after the last busy step.
  a_done_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a preceding step");

  // A start is only issued while the divider is free.
  a_start_when_free : assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire

FILE: rtl/torus_manhattan_neighbour_list.sv
// ----------------------------------------------------------------------------
// torus_manhattan_neighbour_list: von Neumann neighbours on a square torus
// For each cell index, streams the linear index of every other cell within
// the configured cyclic Manhattan radius, column-major scan order.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Signals                         | Content
//  ---------+-----------+---------------------------------+--------------------
//  in_      | slave     | tvalid, tready, tdata[15:0]     | cell_index
//  out_     | master    | tvalid, tready, tdata[15:0],    | neighbour_index,
//           |           | tlast, tuser[0]                 | last, bad_index
//  cfg_     | write     | wen, index[0], wdata[6:0]       | grid_side, radius
//
// Each transaction on in_ first runs through the restoring divider, which
// splits the cell index into row and column. For every column visited, a
// column step then re-arms the row walk, and the scan visits one cell per
// cycle while the out_ channel keeps up. A bad index gives a single result.
// Reset is synchronous and active low; it restores grid_side to 64 and
// radius to 1. in_tready is high only between items; a stalled out_ channel
// stalls the scan, while the last result may still wait in the output
// register when the next input transaction is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module torus_manhattan_neighbour_list
  import tmnl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [DATA_W-1:0]     in_tdata,   // [11:0] cell_index
  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [DATA_W-1:0]          out_tdata,  // [11:0] neighbour_index
  output logic                       out_tlast,
  output logic [0:0]                 out_tuser,  // [0] bad_index
  // Configuration writes.
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_COL,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // Configuration registers.
  logic [SIDE_W-1:0] grid_side_r;
  logic [RAD_W-1:0]  radius_r;

  // Sequencer and walk state.
  state_t            state_r,  state_nxt;
  logic [SIDE_W-1:0] side_r,   side_nxt;
  logic [RAD_W-1:0]  rad_r,    rad_nxt;
  logic [RAD_W-1:0]  rrad_r,   rrad_nxt;   // row radius for current column
  logic [POS_W-1:0]  cx_r,     cx_nxt;
  logic [POS_W-1:0]  cy_r,     cy_nxt;
  logic [POS_W-1:0]  col_r,    col_nxt;
  logic [POS_W-1:0]  row_r,    row_nxt;

  // A result is held back one step so that last can be set on it once the
  // scan is known to have finished.
  logic              hold_vld_r, hold_vld_nxt;
  logic [IDX_W-1:0]  hold_idx_r, hold_idx_nxt;
  logic              hold_bad_r, hold_bad_nxt;

  // Output register.
  logic              out_vld_r,  out_vld_nxt;
  logic [IDX_W-1:0]  out_idx_r,  out_idx_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_bad_r,  out_bad_nxt;

  // Effective configuration, saturated to the supported ranges.
  logic [SIDE_W-1:0] side_eff;
  logic [RAD_W-1:0]  rad_eff;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              in_fire;
  logic              out_free;
  logic              is_center;
  logic              emit;
  logic              can_go;
  logic              push_mid;
  logic              push_last;
  logic [POS_W-1:0]  dx;
  logic [LIN_W-1:0]  lin;
  walk_t             rwalk;
  walk_t             cwalk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= GRID_SIDE_RST;
      radius_r    <= RADIUS_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_GRID_SIDE: grid_side_r <= cfg_wdata;
        REG_RADIUS:    radius_r    <= cfg_wdata[RAD_W-1:0];
      endcase
    end
  end

  always_comb begin
    side_eff = grid_side_r;
    if (grid_side_r < SIDE_W'(MIN_SIDE)) begin
      side_eff = SIDE_W'(MIN_SIDE);
    end else if (grid_side_r > SIDE_W'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end
    rad_eff = radius_r;
    if (radius_r < RAD_W'(MIN_RADIUS)) begin
      rad_eff = RAD_W'(MIN_RADIUS);
    end else if (radius_r > RAD_W'(MAX_RADIUS)) begin
      rad_eff = RAD_W'(MAX_RADIUS);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign div_req.start    = in_fire;
  assign div_req.dividend = in_tdata[IDX_W-1:0];
  assign div_req.divisor  = side_eff;

  tmnl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Per-cell arithmetic used by the scan.
  assign out_free  = !out_vld_r || out_tready;
  assign is_center = (col_r == cx_r) && (row_r == cy_r);
  assign emit      = !is_center;
  assign can_go    = !emit || !hold_vld_r || out_free;
  assign push_mid  = (state_r == ST_SCAN) && emit && hold_vld_r && out_free;
  assign push_last = (state_r == ST_FLUSH) && out_free;
  assign dx        = cyc_dist(col_r, cx_r, side_r);
  assign lin       = LIN_W'(row_r) * LIN_W'(side_r) + LIN_W'(col_r);
  assign rwalk     = next_pos(row_r, cy_r, rrad_r, side_r);
  assign cwalk     = next_pos(col_r, cx_r, rad_r, side_r);

  always_comb begin
    state_nxt    = state_r;
    side_nxt     = side_r;
    rad_nxt      = rad_r;
    rrad_nxt     = rrad_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    hold_vld_nxt = hold_vld_r;
    hold_idx_nxt = hold_idx_r;
    hold_bad_nxt = hold_bad_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          side_nxt  = side_eff;
          rad_nxt   = rad_eff;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient >= IDX_W'(side_r)) begin
            // Index outside the grid: one flagged result, index zero.
            hold_vld_nxt = 1'b1;
            hold_idx_nxt = '0;
            hold_bad_nxt = 1'b1;
            state_nxt    = ST_FLUSH;
          end else begin
            cx_nxt    = div_rsp.remainder;
            cy_nxt    = div_rsp.quotient[POS_W-1:0];
            col_nxt   = first_pos(div_rsp.remainder, rad_r, side_r);
            state_nxt = ST_COL;
          end
        end
      end
      ST_COL: begin
        rrad_nxt  = rad_r - dx[RAD_W-1:0];
        row_nxt   = first_pos(cy_r, rad_r - dx[RAD_W-1:0], side_r);
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (can_go) begin
          if (emit) begin
            hold_vld_nxt = 1'b1;
            hold_idx_nxt = lin[IDX_W-1:0];
            hold_bad_nxt = 1'b0;
          end
          if (!rwalk.done) begin
            row_nxt = rwalk.pos;
          end else if (!cwalk.done) begin
            col_nxt   = cwalk.pos;
            state_nxt = ST_COL;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (push_last) begin
          hold_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_vld_nxt  = out_vld_r;
    out_idx_nxt  = out_idx_r;
    out_last_nxt = out_last_r;
    out_bad_nxt  = out_bad_r;
    if (push_mid || push_last) begin
      out_vld_nxt  = 1'b1;
      out_idx_nxt  = hold_idx_r;
      out_last_nxt = push_last;
      out_bad_nxt  = hold_bad_r;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      side_r     <= GRID_SIDE_RST;
      rad_r      <= RADIUS_RST;
      rrad_r     <= '0;
      cx_r       <= '0;
      cy_r       <= '0;
      col_r      <= '0;
      row_r      <= '0;
      hold_vld_r <= 1'b0;
      hold_idx_r <= '0;
      hold_bad_r <= 1'b0;
      out_vld_r  <= 1'b0;
      out_idx_r  <= '0;
      out_last_r <= 1'b0;
      out_bad_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      side_r     <= side_nxt;
      rad_r      <= rad_nxt;
      rrad_r     <= rrad_nxt;
      cx_r       <= cx_nxt;
      cy_r       <= cy_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      hold_vld_r <= hold_vld_nxt;
      hold_idx_r <= hold_idx_nxt;
      hold_bad_r <= hold_bad_nxt;
      out_vld_r  <= out_vld_nxt;
      out_idx_r  <= out_idx_nxt;
      out_last_r <= out_last_nxt;
      out_bad_r  <= out_bad_nxt;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = DATA_W'(out_idx_r);
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_bad_r;

`ifndef NO_ASSERTIONS
  // A bad-index result is always the only and final one for its input.
  a_bad_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_bad_r) |-> (out_last_r && (out_idx_r == '0)))
    else $error("bad index result not last or not zero");

  // Every scan leaves at least one result pending for the final flag.
  a_flush_has_item : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> hold_vld_r)
    else $error("flush without a held result");

  // The walk never leaves the grid.
  a_walk_in_grid : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |->
      ((SIDE_W'(col_r) < side_r) && (SIDE_W'(row_r) < side_r)))
    else $error("scan position outside the grid");

  // Emitted neighbours never name the center cell itself.
  a_center_skipped : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && is_center) |=> (hold_idx_r == $past(hold_idx_r)))
    else $error("center cell written as a neighbour");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_torus_manhattan_neighbour_list.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_torus_manhattan_neighbour_list: self-checking bench for the torus
// neighbour list generator
// A directed table covers the reset settings, saturated register values,
// small wrapping tori and out-of-grid cell indexes. Random phases follow,
// each with its own grid side and radius. Every result transaction is
// checked against this bench's behavioral neighbour scan or typed-in error result.
// ----------------------------------------------------------------------------

module tb_torus_manhattan_neighbour_list
  import tmnl_pkg::*;
();

  // Far above the slowest legal run: about 400 cells, up to 60 neighbours
  // each, with slow receiver patterns and one long receiver hold-off.
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_CELLS  = 380;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AFTER    = 300;
  localparam int DRAIN_CYCLES  = 50;
  localparam int MAX_NBRS      = 60;

  // One expected result transaction.
  typedef struct {
    logic [IDX_W-1:0] nbr;
    logic             last;
    logic             bad;
  } nbr_result_t;

  // Kinds of rows in the directed table. ROW_BAD rows carry their expected
  // error result typed in directly; ROW_CELL rows go through the predictor.
  typedef enum logic [1:0] {
    ROW_CELL,
    ROW_BAD,
    ROW_SIDE,
    ROW_RADIUS
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [IDX_W-1:0] value;
  } stim_row_t;

  // Receiver behavior, switched at random intervals.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_HALF,
    RX_SLOW
  } rx_mode_t;

  localparam int DIRECTED_ROWS = 36;

  // Directed stimulus. Register rows are applied only once the block has
  // returned every outstanding result.
  stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    // Reset settings: 64 x 64 torus, radius 1, corner and middle cells.
    '{ROW_CELL,   12'd0},
    '{ROW_CELL,   12'd4095},
    '{ROW_CELL,   12'd2080},
    '{ROW_CELL,   12'd63},
    // Smallest torus with the widest radius: the wrap reaches every cell
    // from several directions, each must still appear only once.
    '{ROW_SIDE,   12'd2},
    '{ROW_RADIUS, 12'd5},
    '{ROW_CELL,   12'd0},
    '{ROW_CELL,   12'd3},
    '{ROW_BAD,    12'd4},
    '{ROW_BAD,    12'd4095},
    // Zero side and zero radius saturate up to 2 and 1.
    '{ROW_SIDE,   12'd0},
    '{ROW_RADIUS, 12'd0},
    '{ROW_CELL,   12'd1},
    '{ROW_BAD,    12'd4},
    // All-ones register values saturate down to 64 and 5: 60 neighbours.
    '{ROW_SIDE,   12'd127},
    '{ROW_RADIUS, 12'd7},
    '{ROW_CELL,   12'd0},
    '{ROW_CELL,   12'd2080},
    '{ROW_CELL,   12'd4095},
    // Odd side, radius past the half width.
    '{ROW_SIDE,   12'd5},
    '{ROW_RADIUS, 12'd3},
    '{ROW_CELL,   12'd12},
    '{ROW_CELL,   12'd24},
    '{ROW_BAD,    12'd25},
    // Side of one saturates up, radius six saturates down.
    '{ROW_SIDE,   12'd1},
    '{ROW_RADIUS, 12'd6},
    '{ROW_CELL,   12'd2},
    '{ROW_BAD,    12'd4},
    '{ROW_SIDE,   12'd3},
    '{ROW_RADIUS, 12'd1},
    '{ROW_CELL,   12'd8},
    '{ROW_BAD,    12'd9},
    // Just above the largest side.
    '{ROW_SIDE,   12'd65},
    '{ROW_RADIUS, 12'd2},
    '{ROW_CELL,   12'd4095},
    '{ROW_SIDE,   12'd64}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic [0:0]            out_tuser;
  logic                  cfg_wen    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_GRID_SIDE;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // Bench copy of the two registers, as written (saturation is applied when
  // a cell is predicted, just as the block does it).
  logic [SIDE_W-1:0] side_setting   = GRID_SIDE_RST;
  logic [RAD_W-1:0]  radius_setting = RADIUS_RST;

  nbr_result_t expected_nbrs [$];
  int          error_count  = 0;
  int          cycle_count  = 0;
  int          burst_left   = 0;
  int          results_seen = 0;

  // Receiver pattern state, owned by the receiver process.
  rx_mode_t    rx_mode      = RX_OPEN;
  int          rx_mode_left = 0;
  int          hold_left    = 0;
  bit          hold_done    = 1'b0;

  torus_manhattan_neighbour_list i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [11:0] cell_index, [15:12] zero
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [11:0] neighbour_index, [15:12] zero
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),  // [0] bad_index
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Grid side after saturation to the legal range.
  function automatic int clamped_side();
    int s;
    s = side_setting;
    if (s < MIN_SIDE) s = MIN_SIDE;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s;
  endfunction

  // Distance between two coordinates on a ring of n cells.
  function automatic int ring_gap(input int a, input int b, input int n);
    int d;
    d = (a > b) ? a - b : b - a;
    if (d > n / 2) d = n - d;
    return d;
  endfunction

  // Append one expected result at the tail of the queue.
  task automatic queue_expected(input nbr_result_t res);
    expected_nbrs.insert(expected_nbrs.size(), res);
  endtask

  // Scan the torus column by column, rows inside, and queue every cell whose
  // wrapped Manhattan distance from the center lies in 1..radius. A center
  // outside the grid gives a single error result instead.
  task automatic predict_neighbours(input logic [IDX_W-1:0] cell_idx);
    int               side;
    int               rad;
    int               cx;
    int               cy;
    int               man_dist;
    int               n_hits;
    logic [IDX_W-1:0] hits [MAX_NBRS];
    nbr_result_t      res;
    side   = clamped_side();
    rad    = radius_setting;
    n_hits = 0;
    if (rad < MIN_RADIUS) rad = MIN_RADIUS;
    if (rad > MAX_RADIUS) rad = MAX_RADIUS;
    if (int'(cell_idx) >= side * side) begin
      res.nbr  = '0;
      res.last = 1'b1;
      res.bad  = 1'b1;
      queue_expected(res);
    end else begin
      cx = int'(cell_idx) % side;
      cy = int'(cell_idx) / side;
      for (int col = 0; col < side; col++) begin
        for (int row = 0; row < side; row++) begin
          man_dist = ring_gap(cx, col, side) + ring_gap(cy, row, side);
          if (man_dist >= 1 && man_dist <= rad && n_hits < MAX_NBRS) begin
            hits[n_hits] = IDX_W'(col + row * side);
            n_hits++;
          end
        end
      end
      for (int i = 0; i < n_hits; i++) begin
        res.nbr  = hits[i];
        res.last = (i == n_hits - 1);
        res.bad  = 1'b0;
        queue_expected(res);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Offer one cell on the input channel. The sender runs in bursts: inside
  // a burst the valid stays high from one transaction to the next, between
  // bursts it drops for a random gap (sometimes none at all).
  task automatic offer_cell(input logic [IDX_W-1:0] cell_idx, input bit typed_bad);
    int          gap;
    nbr_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(DATA_W - IDX_W){1'b0}}, cell_idx};
    do @(posedge clk); while (!in_tready);
    // The transaction was accepted at this edge; queue what it must return.
    if (typed_bad) begin
      res.nbr  = '0;
      res.last = 1'b1;
      res.bad  = 1'b1;
      queue_expected(res);
    end else begin
      predict_neighbours(cell_idx);
    end
  endtask

  // Register writes happen only with the block idle: the input is withdrawn
  // and every queued result must have come back first.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_nbrs.size() != 0);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    if (idx == REG_GRID_SIDE) begin
      side_setting = value;
    end else begin
      radius_setting = value[RAD_W-1:0];
    end
  endtask

  // Receiver: check each result transaction, then pick the next ready value.
  always @(posedge clk) begin : rx_side
    nbr_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_nbrs.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%0d tlast=%0b tuser=%0b",
                                  out_tdata, out_tlast, out_tuser));
      end else begin
        exp_res = expected_nbrs.pop_front();
        if (out_tdata !== {{(DATA_W - IDX_W){1'b0}}, exp_res.nbr}) begin
          report_mismatch($sformatf("neighbour_index %0d, expected %0d",
                                    out_tdata, exp_res.nbr));
        end
        if (out_tlast !== exp_res.last) begin
          report_mismatch($sformatf("last %0b, expected %0b (neighbour %0d)",
                                    out_tlast, exp_res.last, exp_res.nbr));
        end
        if (out_tuser[0] !== exp_res.bad) begin
          report_mismatch($sformatf("bad_index %0b, expected %0b (neighbour %0d)",
                                    out_tuser[0], exp_res.bad, exp_res.nbr));
        end
      end
    end

    // One long hold-off once enough results have passed, started while the
    // sender is offering: it keeps offering, so the block backs up and must
    // stall its input.
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER && in_tvalid) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(32, 256);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_OPEN: begin
          out_tready <= 1'b1;
        end
        RX_HALF: begin
          out_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_tready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_torus_manhattan_neighbour_list: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int               phase_cells;
    int               eff;
    int               pick;
    int               sent;
    logic [IDX_W-1:0] cell_idx;
    sent = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      case (directed_rows[i].kind)
        ROW_CELL: begin
          offer_cell(directed_rows[i].value, 1'b0);
        end
        ROW_BAD: begin
          offer_cell(directed_rows[i].value, 1'b1);
        end
        ROW_SIDE: begin
          write_reg(REG_GRID_SIDE, directed_rows[i].value[CFG_DATA_W-1:0]);
        end
        default: begin
          write_reg(REG_RADIUS, directed_rows[i].value[CFG_DATA_W-1:0]);
        end
      endcase
    end

    // Random phases: fresh registers, then a run of cells. Sides are mostly
    // small so the scans stay short; a few phases use the full 64 or a value
    // outside the legal range. Radius writes carry random upper bits.
    while (sent < RANDOM_CELLS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        write_reg(REG_GRID_SIDE, CFG_DATA_W'($urandom_range(2, 10)));
      end else if (pick <= 7) begin
        write_reg(REG_GRID_SIDE, CFG_DATA_W'($urandom_range(11, 64)));
      end else if (pick == 8) begin
        write_reg(REG_GRID_SIDE, CFG_DATA_W'(MAX_SIDE));
      end else begin
        write_reg(REG_GRID_SIDE, CFG_DATA_W'($urandom_range(0, 127)));
      end
      write_reg(REG_RADIUS, CFG_DATA_W'($urandom_range(0, 127)));

      eff         = clamped_side();
      phase_cells = $urandom_range(10, 30);
      for (int k = 0; k < phase_cells && sent < RANDOM_CELLS; k++) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          cell_idx = IDX_W'($urandom_range(0, eff * eff - 1));
        end else if (pick == 7) begin
          cell_idx = IDX_W'(eff * eff - 1);
        end else if (pick == 8) begin
          // First index past the grid, where one exists.
          cell_idx = (eff * eff > 4095) ? IDX_W'(4095) : IDX_W'(eff * eff);
        end else begin
          cell_idx = IDX_W'($urandom_range(0, 4095));
        end
        offer_cell(cell_idx, 1'b0);
        sent++;
      end
    end

    // Drain, then give the block time to show any stray result.
    in_tvalid <= 1'b0;
    while (expected_nbrs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_torus_manhattan_neighbour_list: PASS");
    end else begin
      $display("tb_torus_manhattan_neighbour_list: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tmnl_pkg.sv
rtl/tmnl_div.sv
rtl/torus_manhattan_neighbour_list.sv
tb/sv/tb_torus_manhattan_neighbour_list.sv
